@@ hdl/smc_pkg.sv @@
// Package for the substring match counter: widths, codes, the result record
// and the ASCII case fold. No dependencies; every other file uses it.
package smc_pkg;

  localparam int UNIT_W       = 16;
  localparam int POS_W        = 16;
  localparam int COUNT_W      = 24;
  localparam int LEN_W        = 4;
  localparam int TERM_UNITS   = 8;
  localparam int TSEL_W       = $clog2(TERM_UNITS);
  localparam int TERM_MAX_DEF = 8;
  localparam int CFG_W        = 64;
  localparam int REG_IDX_W    = 3;
  localparam int ACT_W        = 2;

  // Input actions.
  localparam logic [ACT_W-1:0] ACT_UNIT     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_END_LINE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_END_TEXT = 2'd2;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_TERM_LOW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TERM_HIGH  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_TERM_LEN   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CASE_SENS  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_LN  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ANCHOR_COL = 3'd5;

  localparam logic [UNIT_W-1:0]  CH_UPPER_A = 16'h0041;
  localparam logic [UNIT_W-1:0]  CH_UPPER_Z = 16'h005A;
  localparam logic [UNIT_W-1:0]  CH_LOWER_A = 16'h0061;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [POS_W-1:0]   POS_MAX    = '1;

  typedef logic [TERM_UNITS-1:0][UNIT_W-1:0] term_t;

  typedef struct packed {
    logic               hit;
    logic [POS_W-1:0]   hit_line;
    logic [POS_W-1:0]   hit_column;
    logic [COUNT_W-1:0] total_count;
    logic [COUNT_W-1:0] before_count;
    logic               exact_found;
    logic [COUNT_W-1:0] exact_ordinal;
    logic               any_match;
    logic [COUNT_W-1:0] final_index;
    logic               done_res;
  } res_t;

  // Folds ASCII uppercase to lowercase unless the compare is exact.
  function automatic logic [UNIT_W-1:0] fold_unit(input logic [UNIT_W-1:0] u,
                                                  input logic case_sens);
    logic [UNIT_W-1:0] r;
    r = u;
    if (!case_sens && u >= CH_UPPER_A && u <= CH_UPPER_Z) begin
      r = u - CH_UPPER_A + CH_LOWER_A;
    end
    return r;
  endfunction

endpackage

@@ hdl/smc_in_if.sv @@
// Input channel of the substring match counter: one action and code unit.
// Depends on smc_pkg.
interface smc_in_if;
  logic                          valid;
  logic                          ready;
  logic [smc_pkg::ACT_W-1:0]     action;
  logic [smc_pkg::UNIT_W-1:0]    code_unit;

  modport source (output valid, action, code_unit, input ready);
  modport sink (input valid, action, code_unit, output ready);
endinterface

@@ hdl/smc_out_if.sv @@
// Result channel of the substring match counter: one result per input item.
// Depends on smc_pkg.
interface smc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic [smc_pkg::POS_W-1:0]     hit_line;
  logic [smc_pkg::POS_W-1:0]     hit_column;
  logic [smc_pkg::COUNT_W-1:0]   total_count;
  logic [smc_pkg::COUNT_W-1:0]   before_count;
  logic                          exact_found;
  logic [smc_pkg::COUNT_W-1:0]   exact_ordinal;
  logic                          any_match;
  logic [smc_pkg::COUNT_W-1:0]   final_index;
  logic                          done_res;

  modport source (output valid, hit, hit_line, hit_column, total_count, before_count,
                  exact_found, exact_ordinal, any_match, final_index, done_res,
                  input ready);
  modport sink (input valid, hit, hit_line, hit_column, total_count, before_count,
                exact_found, exact_ordinal, any_match, final_index, done_res,
                output ready);
endinterface

@@ hdl/smc_cell.sv @@
// One cell of the window row: holds one recent code unit, passes it on to the
// next cell and compares the unit it receives with its term unit. Uses smc_pkg.
module smc_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       shift,
  input  logic                       clear,
  input  logic [smc_pkg::UNIT_W-1:0] unit_in,
  input  smc_pkg::term_t             term,
  input  logic [smc_pkg::LEN_W-1:0]  len,
  input  logic                       case_sens,
  output logic [smc_pkg::UNIT_W-1:0] unit_out,
  output logic                       eq
);
  import smc_pkg::*;

  logic [UNIT_W-1:0] unit_q;
  logic [LEN_W-1:0]  sel;

  // The unit arriving here after the shift lines up with term unit len-1-IDX.
  assign sel = len - LEN_W'(IDX) - LEN_W'(1);
  assign eq  = fold_unit(unit_in, case_sens) == fold_unit(term[sel[TSEL_W-1:0]], case_sens);

  // Stored unit moves one place along the row on every code unit.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      unit_q <= '0;
    end else if (shift) begin
      unit_q <= unit_in;
    end
  end

  assign unit_out = unit_q;
endmodule

@@ hdl/smc_track.sv @@
// Position and count tracking: turns the cell row's compare vector into a
// result and keeps line, column and match counters. Uses smc_pkg.
module smc_track #(
  parameter int TERM_MAX = smc_pkg::TERM_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [smc_pkg::ACT_W-1:0]   action,
  input  logic [TERM_MAX-1:0]         eq,
  input  logic [smc_pkg::LEN_W-1:0]   len,
  input  logic [smc_pkg::POS_W-1:0]   anchor_row,
  input  logic [smc_pkg::POS_W-1:0]   anchor_col,
  output smc_pkg::res_t               res
);
  import smc_pkg::*;

  logic [POS_W-1:0]   line_number, line_number_next;
  logic [POS_W-1:0]   column_number, column_number_next;
  logic [POS_W:0]     earliest_start, earliest_start_next;
  logic [COUNT_W-1:0] match_total, match_total_next;
  logic [COUNT_W-1:0] before_total, before_total_next;
  logic [COUNT_W-1:0] exact_index, exact_index_next;
  logic               exact_seen, exact_seen_next;

  logic [TERM_MAX-1:0] mask;
  logic [POS_W-1:0]    start;
  logic [COUNT_W-1:0]  idx;
  logic [COUNT_W-1:0]  last;
  logic                hit;

  // Only the first len cells take part in the compare.
  always_comb begin
    for (int j = 0; j < TERM_MAX; j++) begin
      mask[j] = LEN_W'(j) < len;
    end
  end

  assign start = column_number - POS_W'(len) + POS_W'(1);
  assign hit = (action == ACT_UNIT) && (len != '0) &&
               (({1'b0, column_number} + (POS_W+1)'(1)) >= (POS_W+1)'(len)) &&
               ({1'b0, start} >= earliest_start) && (&(eq | ~mask));

  assign idx  = exact_seen ? exact_index : before_total;
  assign last = match_total - COUNT_W'(1);

  // Next state and the result for the item presented now.
  always_comb begin
    line_number_next    = line_number;
    column_number_next  = column_number;
    earliest_start_next = earliest_start;
    match_total_next    = match_total;
    before_total_next   = before_total;
    exact_index_next    = exact_index;
    exact_seen_next     = exact_seen;
    res                 = '0;

    case (action)
      ACT_UNIT: begin
        if (hit) begin
          if (line_number == anchor_row && start == anchor_col) begin
            exact_index_next = match_total;
            exact_seen_next  = 1'b1;
          end
          if (line_number < anchor_row ||
              (line_number == anchor_row && start < anchor_col)) begin
            before_total_next = (before_total != COUNT_MAX) ? before_total + COUNT_W'(1)
                                                            : before_total;
          end
          match_total_next = (match_total != COUNT_MAX) ? match_total + COUNT_W'(1)
                                                        : match_total;
          earliest_start_next = {1'b0, column_number} + (POS_W+1)'(1);
          res.hit        = 1'b1;
          res.hit_line   = line_number;
          res.hit_column = start;
        end
        if (column_number == POS_MAX) begin
          earliest_start_next = {1'b1, {POS_W{1'b0}}};
        end else begin
          column_number_next = column_number + POS_W'(1);
        end
      end
      ACT_END_LINE: begin
        column_number_next  = '0;
        earliest_start_next = '0;
        if (line_number != POS_MAX) begin
          line_number_next = line_number + POS_W'(1);
        end
      end
      ACT_END_TEXT: begin
        res.done_res = 1'b1;
        if (match_total != '0) begin
          res.any_match   = 1'b1;
          res.final_index = (idx > last) ? last : idx;
        end
      end
      default: begin
      end
    endcase

    res.total_count   = match_total_next;
    res.before_count  = before_total_next;
    res.exact_found   = exact_seen_next;
    res.exact_ordinal = exact_seen_next ? exact_index_next : '0;
  end

  // State moves on each accepted item; end of text starts a fresh text.
  always_ff @(posedge clk) begin
    if (rst || (accept && action == ACT_END_TEXT)) begin
      line_number    <= '0;
      column_number  <= '0;
      earliest_start <= '0;
      match_total    <= '0;
      before_total   <= '0;
      exact_index    <= '0;
      exact_seen     <= 1'b0;
    end else if (accept) begin
      line_number    <= line_number_next;
      column_number  <= column_number_next;
      earliest_start <= earliest_start_next;
      match_total    <= match_total_next;
      before_total   <= before_total_next;
      exact_index    <= exact_index_next;
      exact_seen     <= exact_seen_next;
    end
  end
endmodule

@@ hdl/smc_out_buf.sv @@
// Two-entry result buffer between the compare logic and the result channel,
// so items keep flowing while a result waits. Uses smc_pkg.
module smc_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  smc_pkg::res_t din,
  output logic          space,
  input  logic          pop_ready,
  output logic          valid,
  output smc_pkg::res_t dout
);
  import smc_pkg::*;

  logic [1:0] count;
  res_t       slot0;
  res_t       slot1;
  logic       pop;

  assign valid = count != 2'd0;
  assign space = count != 2'd2;
  assign pop   = valid && pop_ready;
  assign dout  = slot0;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  // Slot 0 is always the oldest result.
  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= din;
      end else begin
        slot1 <= din;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (push && pop) begin
      if (count == 2'd1) begin
        slot0 <= din;
      end else begin
        slot0 <= slot1;
        slot1 <= din;
      end
    end
  end
endmodule

@@ hdl/substring_match_counter.sv @@
// Top level of the substring match counter: configuration registers, the row
// of window cells, tracking and the result buffer. Uses smc_pkg and both channels.
//
//   channel  direction  carries
//   text     in         action, code_unit
//   result   out        hit, positions, counts, end-of-text summary
//   wr_*     in         configuration writes (index, 64-bit data)
//
// One item is taken per cycle while the result buffer has space; its result is in the buffer in the cycle after.
// The cell row shifts and compares one unit per cycle; only a full result buffer holds the rate back.
// Reset is synchronous; it restores the register defaults and clears all state.
// The text channel stalls only while both result buffer entries are full.
module substring_match_counter #(
  parameter int TERM_MAX = smc_pkg::TERM_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [smc_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [smc_pkg::CFG_W-1:0]     wr_data,
  smc_in_if.sink                        text,
  smc_out_if.source                     result
);
  import smc_pkg::*;

  logic [CFG_W-1:0]  term_low;
  logic [CFG_W-1:0]  term_high;
  logic [LEN_W-1:0]  term_size;
  logic              exact_case;
  logic [POS_W-1:0]  anchor_row;
  logic [POS_W-1:0]  anchor_col;

  term_t             term;
  logic [LEN_W-1:0]  len;
  logic              accept;
  logic              space;
  logic [TERM_MAX:0][UNIT_W-1:0] chain;
  logic [TERM_MAX-1:0] eq;
  res_t              res;
  res_t              head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_low   <= '0;
      term_high  <= '0;
      term_size  <= LEN_W'(1);
      exact_case <= 1'b1;
      anchor_row <= '0;
      anchor_col <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_TERM_LOW:   term_low   <= wr_data;
        REG_TERM_HIGH:  term_high  <= wr_data;
        REG_TERM_LEN:   term_size  <= wr_data[LEN_W-1:0];
        REG_CASE_SENS:  exact_case <= wr_data[0];
        REG_ANCHOR_LN:  anchor_row <= wr_data[POS_W-1:0];
        REG_ANCHOR_COL: anchor_col <= wr_data[POS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign term = {term_high, term_low};
  assign len  = (term_size > LEN_W'(TERM_MAX)) ? LEN_W'(TERM_MAX) : term_size;

  // Input handshake.
  assign text.ready = space;
  assign accept     = text.valid && space;

  // Row of cells: each hands its stored unit to the next one.
  assign chain[0] = text.code_unit;
  for (genvar j = 0; j < TERM_MAX; j++) begin : g_cell
    smc_cell #(.IDX(j)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept && text.action == ACT_UNIT),
      .clear     (accept && text.action == ACT_END_TEXT),
      .unit_in   (chain[j]),
      .term      (term),
      .len       (len),
      .case_sens (exact_case),
      .unit_out  (chain[j+1]),
      .eq        (eq[j])
    );
  end

  smc_track #(.TERM_MAX(TERM_MAX)) u_track (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (text.action),
    .eq         (eq),
    .len        (len),
    .anchor_row (anchor_row),
    .anchor_col (anchor_col),
    .res        (res)
  );

  smc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .din       (res),
    .space     (space),
    .pop_ready (result.ready),
    .valid     (result.valid),
    .dout      (head)
  );

  // Result channel fields from the oldest buffered result.
  assign result.hit           = head.hit;
  assign result.hit_line      = head.hit_line;
  assign result.hit_column    = head.hit_column;
  assign result.total_count   = head.total_count;
  assign result.before_count  = head.before_count;
  assign result.exact_found   = head.exact_found;
  assign result.exact_ordinal = head.exact_ordinal;
  assign result.any_match     = head.any_match;
  assign result.final_index   = head.final_index;
  assign result.done_res      = head.done_res;
endmodule
